// ===== rtl/dar_pkg.sv =====
// Shared constants, types and the arctangent table for the dE/dx angular recalibration.
// Used by dar_cordic and the top level dedx_angular_recalibration; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dar_pkg;

	// Arctangent unit: iterations and angle widths (degrees in Q16).
	localparam int CORDIC_ITER = 20;
	localparam int Z_W = 25;
	localparam int THETA_W = 23;
	localparam logic [THETA_W-1:0] THETA_MAX = 23'd5898240;

	// Squared-cosine divider: floor(2^62 / (2^32 + t^2)), quotient at most 2^30.
	localparam int C2_Q_W = 31;
	localparam int C2_D_W = 63;
	localparam logic [C2_D_W-1:0] C2_NUM = {1'b1, 62'b0};
	localparam logic [C2_Q_W-1:0] C2_ONE = {1'b1, 30'b0};

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_OLD_NORM  = 3'd0,
		REG_OLD_SLOPE = 3'd1,
		REG_POLY_C0   = 3'd2,
		REG_POLY_C1   = 3'd3,
		REG_POLY_C2   = 3'd4
	} reg_idx_t;

	// Special-case flags of one correction factor.
	typedef struct packed {
		logic neg;
		logic zero_den;
		logic ovf;
	} fac_flags_t;

	// atan(2^-i) in degrees, Q16.
	function automatic logic [Z_W-2:0] atan_deg(input int unsigned i);
		logic [Z_W-2:0] r;
		case (i)
			0: r = 24'd2949120;
			1: r = 24'd1740967;
			2: r = 24'd919879;
			3: r = 24'd466945;
			4: r = 24'd234379;
			5: r = 24'd117304;
			6: r = 24'd58666;
			7: r = 24'd29335;
			8: r = 24'd14668;
			9: r = 24'd7334;
			10: r = 24'd3667;
			11: r = 24'd1833;
			12: r = 24'd917;
			13: r = 24'd458;
			14: r = 24'd229;
			15: r = 24'd115;
			16: r = 24'd57;
			17: r = 24'd29;
			18: r = 24'd14;
			19: r = 24'd7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dar_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, with sideband.
// Standalone; instanced by dedx_angular_recalibration. Requires num >> Q_W < den.
`timescale 1ns / 1ps
`default_nettype none

module dar_div #(
	parameter int NUM_W = 63,
	parameter int DEN_W = 63,
	parameter int Q_W = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] out_side
);

	logic [DEN_W-1:0]  rem_s  [1:Q_W];
	logic [DEN_W-1:0]  den_s  [1:Q_W];
	logic [Q_W-1:0]    nb_s   [1:Q_W];
	logic [Q_W-1:0]    q_s    [1:Q_W];
	logic [SIDE_W-1:0] side_s [1:Q_W];
	logic [Q_W:1]      vld_s;

	for (genvar j = 0; j < Q_W; j++) begin : g_step
		logic [DEN_W-1:0]  rc;
		logic [DEN_W-1:0]  dc;
		logic [Q_W-1:0]    nc;
		logic [Q_W-1:0]    qc;
		logic [SIDE_W-1:0] sc;
		logic              vc;
		logic [DEN_W:0]    r2;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (j == 0) begin : g_in
			assign rc = DEN_W'(num >> Q_W);
			assign dc = den;
			assign nc = num[Q_W-1:0];
			assign qc = '0;
			assign sc = in_side;
			assign vc = in_vld;
		end else begin : g_mid
			assign rc = rem_s[j];
			assign dc = den_s[j];
			assign nc = nb_s[j];
			assign qc = q_s[j];
			assign sc = side_s[j];
			assign vc = vld_s[j];
		end

		// Bring down the next dividend bit and try the subtraction.
		assign r2 = {rc, nc[Q_W-1]};
		assign diff = r2 - {1'b0, dc};
		assign ge = (r2 >= {1'b0, dc});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vc;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
			den_s[j+1]  <= dc;
			nb_s[j+1]   <= {nc[Q_W-2:0], 1'b0};
			q_s[j+1]    <= {qc[Q_W-2:0], ge};
			side_s[j+1] <= sc;
		end
	end

	assign out_vld  = vld_s[Q_W];
	assign quo      = q_s[Q_W];
	assign out_side = side_s[Q_W];

endmodule

`default_nettype wire

// ===== rtl/dar_cordic.sv =====
// Pipelined vectoring arctangent: |atan t| in Q16 degrees, clamped to 0..90 degrees.
// Depends on dar_pkg for the iteration count, widths and the angle table.
`timescale 1ns / 1ps
`default_nettype none

module dar_cordic (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [31:0]                  at,
	output logic                         out_vld,
	output logic [dar_pkg::THETA_W-1:0]  theta
);

	import dar_pkg::*;

	localparam int XW = 42;

	logic signed [XW-1:0]  x_s [1:CORDIC_ITER];
	logic signed [XW-1:0]  y_s [1:CORDIC_ITER];
	logic signed [Z_W-1:0] z_s [1:CORDIC_ITER];
	logic [CORDIC_ITER:1]  vld_s;
	logic signed [Z_W-1:0] zf;

	for (genvar i = 0; i < CORDIC_ITER; i++) begin : g_iter
		logic signed [XW-1:0]  xc;
		logic signed [XW-1:0]  yc;
		logic signed [Z_W-1:0] zc;
		logic                  vc;
		logic signed [Z_W-1:0] step;

		if (i == 0) begin : g_in
			// Start from the vector (1.0 in Q24, t in Q24).
			assign xc = $signed({{(XW-25){1'b0}}, 1'b1, 24'b0});
			assign yc = $signed({{(XW-40){1'b0}}, at, 8'b0});
			assign zc = '0;
			assign vc = in_vld;
		end else begin : g_mid
			assign xc = x_s[i];
			assign yc = y_s[i];
			assign zc = z_s[i];
			assign vc = vld_s[i];
		end

		assign step = $signed({1'b0, atan_deg(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vc;
			end
		end

		always_ff @(posedge clk) begin
			if (!yc[XW-1]) begin
				x_s[i+1] <= xc + (yc >>> i);
				y_s[i+1] <= yc - (xc >>> i);
				z_s[i+1] <= zc + step;
			end else begin
				x_s[i+1] <= xc - (yc >>> i);
				y_s[i+1] <= yc + (xc >>> i);
				z_s[i+1] <= zc - step;
			end
		end
	end

	assign zf = z_s[CORDIC_ITER];
	assign out_vld = vld_s[CORDIC_ITER];

	always_comb begin
		if (zf[Z_W-1]) begin
			theta = '0;
		end else if (zf > $signed({2'b0, THETA_MAX})) begin
			theta = THETA_MAX;
		end else begin
			theta = zf[THETA_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dedx_angular_recalibration.sv =====
// Top level of the dE/dx angular recalibration pipeline and its register port.
// Depends on dar_pkg, dar_div and dar_cordic.
//
// Usage: raise start for one cycle with dedx_value, dedx_uncertainty, tan_dip and
// value_invalid on the inputs; busy is always low, so a transaction is accepted at
// every edge where start is high, one track per clock cycle without gaps.
// Each result is presented for exactly one cycle with done high, carrying
// corrected_value, corrected_uncertainty and saturated, in the order of acceptance.
// The two long dividers lie in series: the squared-cosine divider (31 stages) and
// the factor dividers (COEF_FRAC_BITS + 16 stages), with the arctangent unit running
// alongside the first one. The receiver cannot hold results off, and the pipeline
// never stalls. Coefficients are written through the APB port (byte address
// 4 * index); the user must write them only while no track is in flight, which the
// block itself does not enforce. Reads return the stored values.
// Reset clears all valid bits, so no stray done pulse follows reset, and loads the
// default coefficients.
`timescale 1ns / 1ps
`default_nettype none

module dedx_angular_recalibration #(
	parameter int VALUE_BITS = 32,
	parameter int COEF_FRAC_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_BITS-1:0]  dedx_value,
	input  logic [VALUE_BITS-1:0]  dedx_uncertainty,
	input  logic signed [31:0]     tan_dip,
	input  logic                   value_invalid,
	output logic                   done,
	output logic [VALUE_BITS-1:0]  corrected_value,
	output logic [VALUE_BITS-1:0]  corrected_uncertainty,
	output logic                   saturated
);

	import dar_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam int F = COEF_FRAC_BITS;
	localparam int M_W = F + 16;
	localparam int M_LO = M_W / 2;
	localparam int M_HI = M_W - M_LO;
	localparam int G_W = F + 32;
	localparam int G_LO = G_W / 2;
	localparam int G_HI = G_W - G_LO;
	localparam int PAY_W = 1 + 2 * VB;
	localparam int N_W = 32 + F;
	localparam int D2_W = 35;
	localparam int D3_W = 48;
	localparam int THETA_DLY = 1 + C2_Q_W - CORDIC_ITER;
	localparam logic [M_W-1:0] FMAX = {M_W{1'b1}};

	// Configuration registers.
	logic [31:0] old_norm_q;
	logic [31:0] old_slope_q;
	logic [31:0] poly_c0_q;
	logic [31:0] poly_c1_q;
	logic [31:0] poly_c2_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_norm_q  <= 32'd10666316;
			old_slope_q <= 32'hFFF1533C;
			poly_c0_q   <= 32'd16777216;
			poly_c1_q   <= 32'd20133;
			poly_c2_q   <= 32'd309;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_OLD_NORM:  old_norm_q  <= pwdata;
				REG_OLD_SLOPE: old_slope_q <= pwdata;
				REG_POLY_C0:   poly_c0_q   <= pwdata;
				REG_POLY_C1:   poly_c1_q   <= pwdata;
				REG_POLY_C2:   poly_c2_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_OLD_NORM:  prdata = old_norm_q;
			REG_OLD_SLOPE: prdata = old_slope_q;
			REG_POLY_C0:   prdata = poly_c0_q;
			REG_POLY_C1:   prdata = poly_c1_q;
			REG_POLY_C2:   prdata = poly_c2_q;
			default:       prdata = '0;
		endcase
	end

	// Stage 1: capture, stage 2: t^2.
	logic             vld_s1, vld_s2;
	logic [31:0]      at_s1;
	logic [PAY_W-1:0] pay_s1, pay_s2;
	logic [63:0]      t2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		at_s1  <= tan_dip[31] ? 32'(-tan_dip) : tan_dip;
		pay_s1 <= {value_invalid, dedx_value, dedx_uncertainty};
		t2_s2  <= 64'(at_s1) * 64'(at_s1);
		pay_s2 <= pay_s1;
	end

	// Squared cosine divider and arctangent run side by side.
	logic [C2_D_W-1:0]  c2_den;
	logic               c2_vld;
	logic [C2_Q_W-1:0]  c2_quo;
	logic [PAY_W-1:0]   c2_pay;
	logic               th_vld;
	logic [THETA_W-1:0] th_c;

	assign c2_den = C2_D_W'(t2_s2) + (C2_D_W'(1) << 32);

	dar_div #(
		.NUM_W(C2_D_W),
		.DEN_W(C2_D_W),
		.Q_W(C2_Q_W),
		.SIDE_W(PAY_W)
	) u_c2_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s2),
		.num(C2_NUM),
		.den(c2_den),
		.in_side(pay_s2),
		.out_vld(c2_vld),
		.quo(c2_quo),
		.out_side(c2_pay)
	);

	dar_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s1),
		.at(at_s1),
		.out_vld(th_vld),
		.theta(th_c)
	);

	// Align theta with the divider output.
	logic [THETA_W-1:0]   th_dly_q  [0:THETA_DLY-1];
	logic [THETA_DLY-1:0] thv_dly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thv_dly_q <= '0;
		end else begin
			thv_dly_q <= {thv_dly_q[THETA_DLY-2:0], th_vld};
		end
	end

	always_ff @(posedge clk) begin
		th_dly_q[0] <= th_c;
		for (int k = 1; k < THETA_DLY; k++) begin
			th_dly_q[k] <= th_dly_q[k-1];
		end
	end

	// Stages 34 to 37: both denominators.
	logic [C2_Q_W-1:0]       c2_w;
	logic [THETA_W-1:0]      th_d;
	logic                    vld_s34, vld_s35, vld_s36, vld_s37, vld_s38;
	logic [PAY_W-1:0]        pay_s34, pay_s35, pay_s36, pay_s37, pay_s38;
	logic signed [63:0]      prod2_s34;
	logic [2*THETA_W-1:0]    thsq_s34;
	logic signed [55:0]      pc1_s34;
	logic signed [D2_W-1:0]  den2_s35, den2_s36, den2_s37;
	logic [29:0]             th2_s35;
	logic signed [40:0]      den3a_s35, den3a_s36;
	logic signed [62:0]      pc2_s36;
	logic signed [D3_W-1:0]  den3_s37;

	assign c2_w = C2_ONE - c2_quo;
	assign th_d = th_dly_q[THETA_DLY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s34 <= 1'b0;
			vld_s35 <= 1'b0;
			vld_s36 <= 1'b0;
			vld_s37 <= 1'b0;
			vld_s38 <= 1'b0;
		end else begin
			vld_s34 <= c2_vld & thv_dly_q[THETA_DLY-1];
			vld_s35 <= vld_s34;
			vld_s36 <= vld_s35;
			vld_s37 <= vld_s36;
			vld_s38 <= vld_s37;
		end
	end

	always_ff @(posedge clk) begin
		prod2_s34 <= $signed(old_slope_q) * $signed({1'b0, c2_w});
		thsq_s34  <= (2*THETA_W)'(th_d) * (2*THETA_W)'(th_d);
		pc1_s34   <= $signed(poly_c1_q) * $signed({1'b0, th_d});
		pay_s34   <= c2_pay;

		den2_s35  <= D2_W'($signed(old_norm_q)) + D2_W'(prod2_s34 >>> 30);
		th2_s35   <= thsq_s34[45:16];
		den3a_s35 <= 41'($signed(poly_c0_q)) + 41'(pc1_s34 >>> 16);
		pay_s35   <= pay_s34;

		pc2_s36   <= $signed(poly_c2_q) * $signed({1'b0, th2_s35});
		den2_s36  <= den2_s35;
		den3a_s36 <= den3a_s35;
		pay_s36   <= pay_s35;

		den3_s37  <= D3_W'(den3a_s36) + D3_W'(pc2_s36 >>> 16);
		den2_s37  <= den2_s36;
		pay_s37   <= pay_s36;
	end

	// Stage 38: signs, magnitudes and special cases of both factors.
	logic [31:0]      nm2_w, nm3_w;
	logic [D2_W-2:0]  dm2_w;
	logic [D3_W-2:0]  dm3_w;
	fac_flags_t       fl2_w, fl3_w;
	logic [31:0]      nm2_s38, nm3_s38;
	logic [D2_W-2:0]  dm2_s38;
	logic [D3_W-2:0]  dm3_s38;
	fac_flags_t       fl2_s38, fl3_s38;

	always_comb begin
		nm2_w = old_norm_q[31] ? 32'(-$signed(old_norm_q)) : old_norm_q;
		nm3_w = poly_c0_q[31] ? 32'(-$signed(poly_c0_q)) : poly_c0_q;
		dm2_w = den2_s37[D2_W-1] ? (D2_W-1)'(-den2_s37) : (D2_W-1)'(den2_s37);
		dm3_w = den3_s37[D3_W-1] ? (D3_W-1)'(-den3_s37) : (D3_W-1)'(den3_s37);

		fl2_w.zero_den = (den2_s37 == '0);
		fl2_w.neg = (old_norm_q != '0) && (old_norm_q[31] != den2_s37[D2_W-1]);
		// Quotient would not fit in the factor range.
		fl2_w.ovf = ((D2_W+15)'(nm2_w) >= {dm2_w, 16'h0});

		fl3_w.zero_den = (den3_s37 == '0);
		fl3_w.neg = (poly_c0_q != '0) && (poly_c0_q[31] != den3_s37[D3_W-1]);
		fl3_w.ovf = ((D3_W+15)'(nm3_w) >= {dm3_w, 16'h0});
	end

	always_ff @(posedge clk) begin
		nm2_s38 <= nm2_w;
		nm3_s38 <= nm3_w;
		dm2_s38 <= dm2_w;
		dm3_s38 <= dm3_w;
		fl2_s38 <= fl2_w;
		fl3_s38 <= fl3_w;
		pay_s38 <= pay_s37;
	end

	// Factor dividers.
	logic             f2_vld, f3_vld;
	logic [M_W-1:0]   f2_quo, f3_quo;
	logic [PAY_W+2:0] f2_side;
	logic [2:0]       f3_side;
	fac_flags_t       fl2_d, fl3_d;
	logic [PAY_W-1:0] pay_d;

	dar_div #(
		.NUM_W(N_W),
		.DEN_W(D2_W-1),
		.Q_W(M_W),
		.SIDE_W(PAY_W+3)
	) u_f2_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s38),
		.num({nm2_s38, {F{1'b0}}}),
		.den(dm2_s38),
		.in_side({pay_s38, fl2_s38}),
		.out_vld(f2_vld),
		.quo(f2_quo),
		.out_side(f2_side)
	);

	dar_div #(
		.NUM_W(N_W),
		.DEN_W(D3_W-1),
		.Q_W(M_W),
		.SIDE_W(3)
	) u_f3_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s38),
		.num({nm3_s38, {F{1'b0}}}),
		.den(dm3_s38),
		.in_side(fl3_s38),
		.out_vld(f3_vld),
		.quo(f3_quo),
		.out_side(f3_side)
	);

	assign fl2_d = fac_flags_t'(f2_side[2:0]);
	assign pay_d = f2_side[PAY_W+2:3];
	assign fl3_d = fac_flags_t'(f3_side);

	// Stages 79 to 83: combine factors and scale the transaction's values.
	logic                 vld_s79, vld_s80, vld_s81, vld_s82, vld_s83;
	logic [M_W-1:0]       m2_s79, m3_s79;
	logic                 n2_s79, n3_s79;
	logic [PAY_W-1:0]     pay_s79, pay_s80;
	logic [M_W+M_LO-1:0]  pplo_s80;
	logic [M_W+M_HI-1:0]  pphi_s80;
	logic                 nx_s80;
	logic [2*M_W-1:0]     prod_w;
	logic [G_W-1:0]       g_w;
	logic [G_W-1:0]       g_s81;
	logic                 kill_s81, kill_s82;
	logic [VB-1:0]        v_s81, u_s81;
	logic [VB+G_LO-1:0]   pvlo_s82, pulo_s82;
	logic [VB+G_HI-1:0]   pvhi_s82, puhi_s82;
	logic [VB+G_W-1:0]    pv_w, pu_w;
	logic [VB+31:0]       rv_w, ru_w;
	logic                 clipv_w, clipu_w;
	logic [VB-1:0]        val_s83, unc_s83;
	logic                 sat_s83;

	assign prod_w = (2*M_W)'(pplo_s80) + ((2*M_W)'(pphi_s80) << M_LO);
	assign g_w = prod_w[2*M_W-1:F];

	assign pv_w = (VB+G_W)'(pvlo_s82) + ((VB+G_W)'(pvhi_s82) << G_LO);
	assign pu_w = (VB+G_W)'(pulo_s82) + ((VB+G_W)'(puhi_s82) << G_LO);
	assign rv_w = pv_w[VB+G_W-1:F];
	assign ru_w = pu_w[VB+G_W-1:F];
	assign clipv_w = |rv_w[VB+31:VB];
	assign clipu_w = |ru_w[VB+31:VB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s79 <= 1'b0;
			vld_s80 <= 1'b0;
			vld_s81 <= 1'b0;
			vld_s82 <= 1'b0;
			vld_s83 <= 1'b0;
		end else begin
			vld_s79 <= f2_vld & f3_vld;
			vld_s80 <= vld_s79;
			vld_s81 <= vld_s80;
			vld_s82 <= vld_s81;
			vld_s83 <= vld_s82;
		end
	end

	always_ff @(posedge clk) begin
		// A zero denominator or an out-of-range quotient gives the largest factor.
		m2_s79  <= (fl2_d.zero_den | fl2_d.ovf) ? FMAX : f2_quo;
		m3_s79  <= (fl3_d.zero_den | fl3_d.ovf) ? FMAX : f3_quo;
		n2_s79  <= fl2_d.neg & ~fl2_d.zero_den;
		n3_s79  <= fl3_d.neg & ~fl3_d.zero_den;
		pay_s79 <= pay_d;

		pplo_s80 <= (M_W+M_LO)'(m2_s79) * (M_W+M_LO)'(m3_s79[M_LO-1:0]);
		pphi_s80 <= (M_W+M_HI)'(m2_s79) * (M_W+M_HI)'(m3_s79[M_W-1:M_LO]);
		nx_s80   <= n2_s79 ^ n3_s79;
		pay_s80  <= pay_s79;

		// A negative combined factor or an invalid value gives zero results.
		g_s81    <= g_w;
		kill_s81 <= pay_s80[PAY_W-1] | (nx_s80 && (g_w != '0));
		v_s81    <= pay_s80[2*VB-1:VB];
		u_s81    <= pay_s80[VB-1:0];

		pvlo_s82 <= (VB+G_LO)'(v_s81) * (VB+G_LO)'(g_s81[G_LO-1:0]);
		pvhi_s82 <= (VB+G_HI)'(v_s81) * (VB+G_HI)'(g_s81[G_W-1:G_LO]);
		pulo_s82 <= (VB+G_LO)'(u_s81) * (VB+G_LO)'(g_s81[G_LO-1:0]);
		puhi_s82 <= (VB+G_HI)'(u_s81) * (VB+G_HI)'(g_s81[G_W-1:G_LO]);
		kill_s82 <= kill_s81;

		if (kill_s82) begin
			val_s83 <= '0;
			unc_s83 <= '0;
			sat_s83 <= 1'b0;
		end else begin
			val_s83 <= clipv_w ? {VB{1'b1}} : rv_w[VB-1:0];
			unc_s83 <= clipu_w ? {VB{1'b1}} : ru_w[VB-1:0];
			sat_s83 <= clipv_w | clipu_w;
		end
	end

	assign done                  = vld_s83;
	assign corrected_value       = val_s83;
	assign corrected_uncertainty = unc_s83;
	assign saturated             = sat_s83;

endmodule

`default_nettype wire

// ===== sim/dar_checker.sv =====
// Checker for the dE/dx angular recalibration: mirrors the coefficient registers from
// the APB writes, predicts each track's corrected values and compares them with the
// results. Depends on dar_pkg.
`timescale 1ns / 1ps

module dar_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	input  logic         start,
	input  logic         busy,
	input  logic [31:0]  dedx_value,
	input  logic [31:0]  dedx_uncertainty,
	input  logic [31:0]  tan_dip,
	input  logic         value_invalid,
	input  logic         done,
	input  logic [31:0]  corrected_value,
	input  logic [31:0]  corrected_uncertainty,
	input  logic         saturated,
	output int           fail_count,
	output int           pending,
	output int           checked,
	output int           sat_seen
);
	import dar_pkg::*;

	localparam int FRAC = 24;
	localparam logic [63:0] FAC_MAX = (64'd1 << (FRAC + 16)) - 1;

	typedef struct packed {
		logic [31:0] val;
		logic [31:0] unc;
		logic        sat;
	} track_result_t;

	track_result_t expected_q[$];
	logic signed [31:0] coef [5];

	function automatic logic signed [63:0] asr64(input logic signed [63:0] v, input int s);
		return v >>> s;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [63:0] polar_deg(input logic [63:0] at);
		logic signed [63:0] x, y, z, nx;
		x = 64'sd1 << 24;
		y = at << 8;
		z = 0;
		for (int i = 0; i < CORDIC_ITER; i++) begin
			if (y >= 0) begin
				nx = x + asr64(y, i);
				y = y - asr64(x, i);
				z = z + atan_deg(i);
			end else begin
				nx = x - asr64(y, i);
				y = y + asr64(x, i);
				z = z - atan_deg(i);
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > 64'sd5898240) z = 64'sd5898240;
		return z;
	endfunction

	function automatic logic [63:0] ratio_mag(input logic signed [63:0] num,
			input logic signed [63:0] den, output logic neg);
		logic [127:0] q;
		if (den == 0) begin
			neg = 0;
			return FAC_MAX;
		end
		neg = (num != 0) && ((num < 0) != (den < 0));
		q = ({64'd0, mag64(num)} << FRAC) / {64'd0, mag64(den)};
		return q > FAC_MAX ? FAC_MAX : q[63:0];
	endfunction

	function automatic track_result_t correct_track(input logic [31:0] v, input logic [31:0] u,
			input logic signed [31:0] t, input logic inv);
		track_result_t r;
		logic [63:0] at, m2, m3, g;
		logic [127:0] t2, c2, pv, pu, pg;
		logic signed [63:0] den2, th, th2, den3;
		logic n2, n3;
		r = '0;
		if (inv) return r;
		at = t < 0 ? -64'(t) : 64'(t);
		t2 = at * at;
		c2 = (128'd1 << 30) - (128'd1 << 62) / ((128'd1 << 32) + t2);
		den2 = 64'(coef[REG_OLD_NORM])
			+ asr64(64'(coef[REG_OLD_SLOPE]) * $signed(c2[63:0]), 30);
		m2 = ratio_mag(64'(coef[REG_OLD_NORM]), den2, n2);
		th = polar_deg(at);
		th2 = (th * th) >>> 16;
		den3 = 64'(coef[REG_POLY_C0]) + asr64(64'(coef[REG_POLY_C1]) * th, 16)
			+ asr64(64'(coef[REG_POLY_C2]) * th2, 16);
		m3 = ratio_mag(64'(coef[REG_POLY_C0]), den3, n3);
		pg = ({64'd0, m2} * {64'd0, m3}) >> FRAC;
		g = pg[127:64] != 0 ? '1 : pg[63:0];
		if (n2 != n3 && g != 0) return r;
		pv = ({96'd0, v} * {64'd0, g}) >> FRAC;
		pu = ({96'd0, u} * {64'd0, g}) >> FRAC;
		r.sat = (pv > 128'hFFFF_FFFF) || (pu > 128'hFFFF_FFFF);
		r.val = pv > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : pv[31:0];
		r.unc = pu > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : pu[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		track_result_t e;
		if (!arst_n) begin
			coef[REG_OLD_NORM] = 32'sd10666316;
			coef[REG_OLD_SLOPE] = -32'sd961732;
			coef[REG_POLY_C0] = 32'sd16777216;
			coef[REG_POLY_C1] = 32'sd20133;
			coef[REG_POLY_C2] = 32'sd309;
			expected_q.delete();
			pending = 0;
			fail_count = 0;
			checked = 0;
			sat_seen = 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with no track pending");
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					checked++;
					if (saturated) sat_seen++;
					if (corrected_value !== e.val) begin
						$error("corrected_value exp %0d got %0d", e.val, corrected_value);
						fail_count++;
					end
					if (corrected_uncertainty !== e.unc) begin
						$error("corrected_uncertainty exp %0d got %0d", e.unc,
							corrected_uncertainty);
						fail_count++;
					end
					if (saturated !== e.sat) begin
						$error("saturated exp %0d got %0d", e.sat, saturated);
						fail_count++;
					end
				end
			end
			// Prediction uses the coefficients before a same-edge write.
			if (start && !busy)
				expected_q.push_back(correct_track(dedx_value, dedx_uncertainty,
					tan_dip, value_invalid));
			if (psel && penable && pwrite && pready && paddr[4:2] <= REG_POLY_C2)
				coef[paddr[4:2]] = pwdata;
			pending = expected_q.size();
		end
	end

endmodule

// ===== sim/dedx_angular_recalibration_tb.sv =====
// Testbench top for dedx_angular_recalibration: drives coefficient phases over APB and
// directed plus random tracks, and gives the verdict. Depends on dar_pkg and dar_checker.
`timescale 1ns / 1ps

module dedx_angular_recalibration_tb;
	import dar_pkg::*;

	localparam int LATENCY = 82;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready, start, busy, value_invalid, done, saturated;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata, dedx_value, dedx_uncertainty, tan_dip;
	logic [31:0] corrected_value, corrected_uncertainty;
	int fail_count, pending, checked, sat_seen, tracks_sent;
	longint cycles;

	dedx_angular_recalibration u_dut (.*);

	dar_checker u_chk (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("cycle limit reached");
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_coef(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain_pipeline();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// Drives one track; start stays high across back-to-back transactions.
	task automatic send_track(input logic [31:0] v, input logic [31:0] u,
			input logic [31:0] t, input logic inv, input int gap);
		@(negedge clk);
		start <= 1; dedx_value <= v; dedx_uncertainty <= u; tan_dip <= t; value_invalid <= inv;
		do @(posedge clk); while (busy);
		tracks_sent++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] rand_tan();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $signed($urandom_range(0, 32'h0002_0000)) * ($urandom_range(0, 1) ? 1 : -1);
			2: return $signed($urandom_range(0, 32'h0040_0000)) * ($urandom_range(0, 1) ? 1 : -1);
			3: return $urandom_range(0, 255);
			default: return 32'h8000_0000 + $urandom_range(0, 3);
		endcase
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1000);
			1: return '1 - $urandom_range(0, 100);
			default: return $urandom();
		endcase
	endfunction

	task automatic random_tracks(input int n);
		for (int i = 0; i < n; i++)
			send_track(rand_value(), rand_value(), rand_tan(),
				$urandom_range(0, 15) == 0, ($urandom_range(0, 9) < 3) ? 0 : rand_gap());
		@(negedge clk);
		start <= 0;
	endtask

	task automatic load_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
			input logic [31:0] d, input logic [31:0] e);
		write_coef(REG_OLD_NORM, a);
		write_coef(REG_OLD_SLOPE, b);
		write_coef(REG_POLY_C0, c);
		write_coef(REG_POLY_C1, d);
		write_coef(REG_POLY_C2, e);
	endtask

	initial begin
		logic [31:0] dtan [10];
		cycles = 0; tracks_sent = 0;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		start = 0; dedx_value = 0; dedx_uncertainty = 0; tan_dip = 0; value_invalid = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed tracks with the default coefficients: angle extremes, value extremes,
		// invalid flag and saturation of large values.
		dtan = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'h0010_0000, 32'hFFF0_0000};
		foreach (dtan[i]) send_track(32'hFFFF_FFFF, 32'd1000, dtan[i], 0, i % 2);
		send_track(32'd0, 32'hFFFF_FFFF, 32'h0003_0000, 0, 0);
		send_track(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0003_0000, 1, 0);
		send_track(32'h1234_5678, 32'h0, 32'h0, 0, 1);
		@(negedge clk);
		start <= 0;
		drain_pipeline();

		// A zero denominator and a large factor, then a negative poly_c0 coefficient.
		load_coefs(32'h0100_0000, 32'hFF00_0000, 32'h0100_0000, 32'h0, 32'h0);
		send_track(32'd5000, 32'd70, 32'h7FFF_FFFF, 0, 0);
		send_track(32'd5000, 32'd70, 32'h0, 0, 0);
		send_track(32'hFFFF_FFFF, 32'd70, 32'h0100_0000, 0, 1);
		drain_pipeline();
		load_coefs(32'h0100_0000, 32'h0, 32'hFF00_0000, 32'h0, 32'h0);
		send_track(32'd5000, 32'd70, 32'h0002_0000, 0, 0);
		send_track(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, 1);
		drain_pipeline();
		random_tracks(50);
		drain_pipeline();

		// Random phases at the register extremes, then random coefficients, then the defaults.
		load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		random_tracks(80);
		drain_pipeline();
		load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		random_tracks(80);
		drain_pipeline();
		for (int p = 0; p < 3; p++) begin
			load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
			random_tracks(80);
			drain_pipeline();
		end
		load_coefs(32'sd10666316, -32'sd961732, 32'sd16777216, 32'sd20133, 32'sd309);
		random_tracks(680);
		drain_pipeline();

		$display("%0d tracks sent, %0d results checked, %0d saturated, over 9 coefficient sets",
			tracks_sent, checked, sat_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
